// ===== rtl/mltd_pkg.sv =====
package mltd_pkg;

	localparam int MAX_TASKS_DEF = 32;
	localparam int LEVELS_DEF    = 3;

	localparam int TASK_W  = 16;
	localparam int KEY_W   = 38;
	localparam int BURST_W = 8;
	localparam int TIME_W  = 31;
	localparam int CMD_W   = 3;

	localparam logic signed [KEY_W-1:0] EXPIRED_KEY = 38'sh1F_FFFF_FFFF;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	localparam logic [CMD_W-1:0] CMD_TIMER   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ARRIVAL = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FINISH  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_IO_REQ  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_IO_END  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DECIDE  = 3'd5;

	localparam logic [2:0] REG_LEVEL_ZERO = 3'd0;
	localparam logic [2:0] REG_LEVEL_ONE  = 3'd1;
	localparam logic [2:0] REG_PERIOD     = 3'd2;
	localparam logic [2:0] REG_HIGH_WGT   = 3'd3;
	localparam logic [2:0] REG_LOW_WGT    = 3'd4;
	localparam logic [2:0] REG_SEED       = 3'd5;

	typedef struct packed {
		logic                     in_io;
		logic [TASK_W-1:0]        task_id;
		logic signed [KEY_W-1:0]  key;
		logic [BURST_W-1:0]       bursts;
	} entry_t;

	function automatic logic [15:0] lfsr_next(input logic [15:0] v);
		logic [15:0] n;
		n = v >> 1;
		if (v[0]) begin
			n = n ^ LFSR_TAPS;
		end
		if (n == 16'd0) begin
			n = 16'd1;
		end
		return n;
	endfunction

	function automatic logic [15:0] seed_of(input logic [15:0] s);
		return (s == 16'd0) ? 16'd1 : s;
	endfunction

endpackage

// ===== rtl/multilevel_deadline_task_dispatcher.sv =====
// channel  | dir | tvalid/tready       | tdata / tuser
// s_       | in  | s_tvalid, s_tready  | tdata event word, tuser cmd
// m_       | out | m_tvalid, m_tready  | tdata cpu_task, io_task, table_overflow
// apb      | in  | psel, penable       | paddr, pwdata, prdata (6 registers)
// Timer words finish at accept; a table edit goes from accept through a scan of every
// slot, one slot read per cycle, then through the write-back state back to idle.
// Decide runs a serial tick modulo, the same scan, then LFSR draws (step and wait states).
// Reset clears valid bits, tick count, overflow flag; LFSR and registers take defaults.
// A decide result waits in the output register; a new word is taken meanwhile.
module multilevel_deadline_task_dispatcher #(
	parameter int MAX_TASKS = mltd_pkg::MAX_TASKS_DEF,
	parameter int LEVELS    = mltd_pkg::LEVELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// high_priority, arrival_time, deadline, task_id, event_time, busy_io_task
	input  logic [127:0] s_tdata,
	// cmd
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// cpu_task, io_task, table_overflow
	output logic [39:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int IW  = $clog2(MAX_TASKS);
	localparam int CW  = IW + 1;
	localparam int LVW = $clog2(LEVELS);
	localparam int RS  = 16 + $clog2(LEVELS);
	localparam logic [16:0] RM = 17'((1 << RS) / LEVELS + 1);
	localparam logic [LVW-1:0] LV_ONE = LVW'((1 < LEVELS - 1) ? 1 : LEVELS - 1);
	localparam logic [LVW-1:0] LV_TOP = LVW'(LEVELS - 1);
	localparam int KW = mltd_pkg::KEY_W;
	localparam int TW = mltd_pkg::TASK_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MODT, ST_MODW, ST_SCAN, ST_WRITE, ST_DSTEP, ST_DWAIT, ST_RESULT
	} state_t;

	state_t state_q;

	logic [7:0]  lz_q, l1_q;
	logic [15:0] period_q, seed_q;
	logic [3:0]  hw_q, lw_q;

	logic [2:0]  cmd_q;
	logic        hp_q;
	logic [30:0] arr_q, dl_q, now_q;
	logic [15:0] id_q, busy_q;

	logic [31:0] tick_q;
	logic [15:0] lfsr_q;
	logic        ovf_q;
	logic [MAX_TASKS-1:0] valid_q;

	logic [CW-1:0] rd_q;
	logic          v_s1;
	logic [IW-1:0] idx_s1;
	logic          clr_q;

	logic          free_fnd_q, cm_fnd_q, im_fnd_q, bio_fnd_q;
	logic [IW-1:0] free_idx_q, cm_idx_q, im_idx_q;
	logic [7:0]    cm_b_q, im_b_q;
	logic signed [KW-1:0] bio_key_q;
	logic [TW-1:0] bio_task_q;
	logic                 lb_vld_q  [LEVELS];
	logic signed [KW-1:0] lb_key_q  [LEVELS];
	logic [TW-1:0]        lb_task_q [LEVELS];

	logic [15:0] draws_q;
	logic [15:0] cpu_res_q;
	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;

	logic               mem_we;
	logic [IW-1:0]      mem_waddr;
	mltd_pkg::entry_t   mem_wdata;
	mltd_pkg::entry_t   mem_rdata;

	logic        tmod_done;
	logic [15:0] tmod_rem;

	logic [35:0]    rprod_w;
	logic [15:0]    rq_w;
	logic [15:0]    rrem_w;
	logic [LVW-1:0] lvl_w;

	logic signed [31:0] diff_w;
	logic [3:0]         wgt_w;
	logic signed [36:0] prod_w;
	logic signed [KW-1:0] key_w;

	logic          s_acc;
	logic          cfg_wr;
	logic          e_vld;
	logic [LVW-1:0] e_lvl;
	logic [7:0]    e_b;
	logic          any_cpu;
	logic [TW-1:0] fb_task;
	logic [7:0]    sat_b;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;

	assign diff_w = $signed({1'b0, dl_q}) - $signed({1'b0, arr_q});
	assign wgt_w  = hp_q ? hw_q : lw_q;
	assign prod_w = diff_w * $signed({1'b0, wgt_w});
	assign key_w  = (now_q > dl_q) ? mltd_pkg::EXPIRED_KEY : {prod_w[36], prod_w};

	assign rprod_w = 36'(lfsr_q) * 36'(RM);
	assign rq_w    = rprod_w[RS +: 16];
	assign rrem_w  = lfsr_q - rq_w * 16'(LEVELS);
	assign lvl_w   = rrem_w[LVW-1:0];

	assign e_vld = valid_q[idx_s1];
	assign e_b   = clr_q ? 8'd0 : mem_rdata.bursts;
	assign sat_b = (cm_b_q == 8'hFF) ? cm_b_q : cm_b_q + 8'd1;

	always_comb begin
		if (e_b <= lz_q) begin
			e_lvl = '0;
		end else if (e_b <= l1_q) begin
			e_lvl = LV_ONE;
		end else begin
			e_lvl = LV_TOP;
		end
	end

	always_comb begin
		any_cpu = 1'b0;
		fb_task = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (lb_vld_q[l]) begin
				any_cpu = 1'b1;
				fb_task = lb_task_q[l];
			end
		end
	end

	always_comb begin
		case (paddr[4:2])
			mltd_pkg::REG_LEVEL_ZERO: prdata = {24'd0, lz_q};
			mltd_pkg::REG_LEVEL_ONE:  prdata = {24'd0, l1_q};
			mltd_pkg::REG_PERIOD:     prdata = {16'd0, period_q};
			mltd_pkg::REG_HIGH_WGT:   prdata = {28'd0, hw_q};
			mltd_pkg::REG_LOW_WGT:    prdata = {28'd0, lw_q};
			mltd_pkg::REG_SEED:       prdata = {16'd0, seed_q};
			default:                  prdata = 32'd0;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = mem_rdata;
		mem_wdata.bursts = 8'd0;
		if (state_q == ST_SCAN && v_s1 && clr_q) begin
			mem_we = 1'b1;
		end else if (state_q == ST_WRITE) begin
			mem_wdata.task_id = id_q;
			mem_wdata.key     = key_w;
			mem_waddr         = free_idx_q;
			case (cmd_q)
				mltd_pkg::CMD_ARRIVAL: begin
					mem_we          = free_fnd_q;
					mem_wdata.in_io = 1'b0;
				end
				mltd_pkg::CMD_IO_REQ: begin
					mem_wdata.in_io = 1'b1;
					if (cm_fnd_q) begin
						mem_we           = 1'b1;
						mem_waddr        = cm_idx_q;
						mem_wdata.bursts = sat_b;
					end else begin
						mem_we           = free_fnd_q;
						mem_wdata.bursts = 8'd1;
					end
				end
				mltd_pkg::CMD_IO_END: begin
					mem_wdata.in_io = 1'b0;
					if (im_fnd_q) begin
						mem_we           = 1'b1;
						mem_waddr        = im_idx_q;
						mem_wdata.bursts = im_b_q;
					end else begin
						mem_we = free_fnd_q;
					end
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	mltd_table #(.DEPTH(MAX_TASKS), .AW(IW)) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_q[IW-1:0]),
		.rdata (mem_rdata)
	);

	mltd_smod #(.DW(32), .VW(16)) u_tmod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_MODT),
		.dividend (tick_q),
		.divisor  (period_q),
		.done     (tmod_done),
		.rem      (tmod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			lz_q       <= 8'd3;
			l1_q       <= 8'd10;
			period_q   <= 16'd20;
			hw_q       <= 4'd4;
			lw_q       <= 4'd5;
			seed_q     <= 16'd1;
			tick_q     <= '0;
			lfsr_q     <= 16'd1;
			ovf_q      <= 1'b0;
			valid_q    <= '0;
			rd_q       <= '0;
			v_s1       <= 1'b0;
			clr_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			draws_q    <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_RESULT) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_wr) begin
				case (paddr[4:2])
					mltd_pkg::REG_LEVEL_ZERO: lz_q <= pwdata[7:0];
					mltd_pkg::REG_LEVEL_ONE:  l1_q <= pwdata[7:0];
					mltd_pkg::REG_PERIOD:     period_q <= pwdata[15:0];
					mltd_pkg::REG_HIGH_WGT:   hw_q <= pwdata[3:0];
					mltd_pkg::REG_LOW_WGT:    lw_q <= pwdata[3:0];
					mltd_pkg::REG_SEED: begin
						seed_q <= pwdata[15:0];
						lfsr_q <= mltd_pkg::seed_of(pwdata[15:0]);
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						cmd_q  <= s_tuser;
						hp_q   <= s_tdata[0];
						arr_q  <= s_tdata[31:1];
						dl_q   <= s_tdata[62:32];
						id_q   <= s_tdata[78:63];
						now_q  <= s_tdata[109:79];
						busy_q <= s_tdata[125:110];
						clr_q      <= 1'b0;
						rd_q       <= '0;
						v_s1       <= 1'b0;
						free_fnd_q <= 1'b0;
						cm_fnd_q   <= 1'b0;
						im_fnd_q   <= 1'b0;
						bio_fnd_q  <= 1'b0;
						for (int l = 0; l < LEVELS; l++) begin
							lb_vld_q[l] <= 1'b0;
						end
						case (s_tuser)
							mltd_pkg::CMD_TIMER: tick_q <= tick_q + 32'd1;
							mltd_pkg::CMD_ARRIVAL,
							mltd_pkg::CMD_FINISH,
							mltd_pkg::CMD_IO_REQ,
							mltd_pkg::CMD_IO_END: state_q <= ST_SCAN;
							mltd_pkg::CMD_DECIDE: state_q <= ST_MODT;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_MODT: begin
					state_q <= ST_MODW;
				end
				ST_MODW: begin
					if (tmod_done) begin
						clr_q   <= (period_q != 16'd0) && (tmod_rem == 16'd0);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_q != CW'(MAX_TASKS)) begin
						rd_q   <= rd_q + 1'b1;
						v_s1   <= 1'b1;
						idx_s1 <= rd_q[IW-1:0];
					end else begin
						v_s1 <= 1'b0;
					end
					if (v_s1) begin
						if (!e_vld && !free_fnd_q) begin
							free_fnd_q <= 1'b1;
							free_idx_q <= idx_s1;
						end
						if (e_vld && mem_rdata.task_id == id_q) begin
							if (!mem_rdata.in_io && !cm_fnd_q) begin
								cm_fnd_q <= 1'b1;
								cm_idx_q <= idx_s1;
								cm_b_q   <= mem_rdata.bursts;
							end
							if (mem_rdata.in_io && !im_fnd_q) begin
								im_fnd_q <= 1'b1;
								im_idx_q <= idx_s1;
								im_b_q   <= mem_rdata.bursts;
							end
						end
						if (e_vld && mem_rdata.in_io &&
								(!bio_fnd_q || mem_rdata.key < bio_key_q)) begin
							bio_fnd_q  <= 1'b1;
							bio_key_q  <= mem_rdata.key;
							bio_task_q <= mem_rdata.task_id;
						end
						for (int l = 0; l < LEVELS; l++) begin
							if (e_vld && !mem_rdata.in_io && e_lvl == LVW'(l) &&
									(!lb_vld_q[l] || mem_rdata.key < lb_key_q[l])) begin
								lb_vld_q[l]  <= 1'b1;
								lb_key_q[l]  <= mem_rdata.key;
								lb_task_q[l] <= mem_rdata.task_id;
							end
						end
					end
					if (rd_q == CW'(MAX_TASKS) && !v_s1) begin
						if (cmd_q == mltd_pkg::CMD_DECIDE) begin
							cpu_res_q <= '0;
							draws_q   <= '0;
							state_q   <= any_cpu ? ST_DSTEP : ST_RESULT;
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					case (cmd_q)
						mltd_pkg::CMD_FINISH: begin
							if (cm_fnd_q) begin
								valid_q[cm_idx_q] <= 1'b0;
							end
							if (im_fnd_q) begin
								valid_q[im_idx_q] <= 1'b0;
							end
						end
						mltd_pkg::CMD_ARRIVAL: begin
							if (free_fnd_q) begin
								valid_q[free_idx_q] <= 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end
						mltd_pkg::CMD_IO_REQ: begin
							if (!cm_fnd_q) begin
								if (free_fnd_q) begin
									valid_q[free_idx_q] <= 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
						end
						mltd_pkg::CMD_IO_END: begin
							if (!im_fnd_q) begin
								if (free_fnd_q) begin
									valid_q[free_idx_q] <= 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
						end
						default: begin
						end
					endcase
					state_q <= ST_IDLE;
				end
				ST_DSTEP: begin
					lfsr_q  <= mltd_pkg::lfsr_next(lfsr_q);
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (lb_vld_q[lvl_w]) begin
						cpu_res_q <= lb_task_q[lvl_w];
						state_q   <= ST_RESULT;
					end else if (draws_q == 16'hFFFE) begin
						cpu_res_q <= fb_task;
						state_q   <= ST_RESULT;
					end else begin
						draws_q <= draws_q + 16'd1;
						state_q <= ST_DSTEP;
					end
				end
				ST_RESULT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {7'd0, ovf_q,
							(busy_q != 16'd0) ? busy_q : (bio_fnd_q ? bio_task_q : 16'd0),
							cpu_res_q};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_clear_writes_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && mem_we) |-> clr_q)
		else $error("scan write without burst clear");

	a_result_from_fsm: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_RESULT))
		else $error("result raised outside result state");

	a_idle_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !v_s1)
		else $error("scan stage busy while idle");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DWAIT) |-> (rrem_w < 16'(LEVELS)))
		else $error("drawn level out of range");

endmodule

// ===== rtl/mltd_table.sv =====
module mltd_table #(
	parameter int DEPTH = mltd_pkg::MAX_TASKS_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  mltd_pkg::entry_t      wdata,
	input  logic [AW-1:0]         raddr,
	output mltd_pkg::entry_t      rdata
);

	mltd_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/mltd_smod.sv =====
module mltd_smod #(
	parameter int DW = 32,
	parameter int VW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [VW-1:0] rem
);

	localparam int CNW = $clog2(DW + 1);

	logic [DW-1:0]  sh_q;
	logic [VW-1:0]  r_q;
	logic [CNW-1:0] cnt_q;
	logic           run_q;
	logic           done_q;
	logic [VW:0]    t_w;
	logic [VW:0]    nxt_w;

	assign t_w   = {r_q, sh_q[DW-1]};
	assign nxt_w = (t_w >= {1'b0, divisor}) ? (t_w - {1'b0, divisor}) : t_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				sh_q  <= dividend;
				r_q   <= '0;
				cnt_q <= CNW'(DW);
				run_q <= 1'b1;
			end else if (run_q) begin
				sh_q  <= sh_q << 1;
				r_q   <= nxt_w[VW-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule

// ===== dv/mltd_checker.sv =====
`timescale 1ns / 1ps
module mltd_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,
	input  logic [2:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [39:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic         pready,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output int           errors,
	output int           pending
);

	localparam int NSLOT = mltd_pkg::MAX_TASKS_DEF;
	localparam int NLVL  = mltd_pkg::LEVELS_DEF;

	typedef struct {
		logic [15:0] cpu;
		logic [15:0] io;
		logic        ovf;
	} decision_t;

	decision_t    decisions_due[$];
	bit           occupied[NSLOT];
	bit           on_io[NSLOT];
	logic [15:0]  owner[NSLOT];
	longint       sort_key[NSLOT];
	int unsigned  bursts[NSLOT];
	logic [31:0]  ticks;
	logic [15:0]  lfsr;
	bit           full_seen;
	int unsigned  lim0, lim1, period, w_high, w_low;
	logic [15:0]  seed;

	function automatic logic [15:0] seed_fix(input logic [15:0] s);
		return (s == 16'd0) ? 16'd1 : s;
	endfunction

	task automatic clear_state();
		for (int i = 0; i < NSLOT; i++) begin
			occupied[i] = 0;
		end
		ticks = 0;
		full_seen = 0;
		lim0 = 3;
		lim1 = 10;
		period = 20;
		w_high = 4;
		w_low = 5;
		seed = 16'd1;
		lfsr = 16'd1;
	endtask

	function automatic int lookup(input logic [15:0] id, input bit io);
		for (int i = 0; i < NSLOT; i++) begin
			if (occupied[i] && on_io[i] == io && owner[i] == id) begin
				return i;
			end
		end
		return -1;
	endfunction

	task automatic place(input logic [15:0] id, input bit io, input longint k,
			input int unsigned b);
		for (int i = 0; i < NSLOT; i++) begin
			if (!occupied[i]) begin
				occupied[i] = 1;
				on_io[i] = io;
				owner[i] = id;
				sort_key[i] = k;
				bursts[i] = b;
				return;
			end
		end
		full_seen = 1;
	endtask

	function automatic int level_of(input int unsigned b);
		if (b <= lim0) begin
			return 0;
		end
		if (b <= lim1) begin
			return 1;
		end
		return NLVL - 1;
	endfunction

	function automatic int lowest_key(input bit io, input int lvl);
		int best;
		best = -1;
		for (int i = 0; i < NSLOT; i++) begin
			if (occupied[i] && on_io[i] == io && (lvl < 0 || level_of(bursts[i]) == lvl)) begin
				if (best < 0 || sort_key[i] < sort_key[best]) begin
					best = i;
				end
			end
		end
		return best;
	endfunction

	function automatic logic [15:0] draw();
		logic [15:0] n;
		n = lfsr >> 1;
		if (lfsr[0]) begin
			n = n ^ 16'hB400;
		end
		if (n == 16'd0) begin
			n = 16'd1;
		end
		lfsr = n;
		return n;
	endfunction

	task automatic dispatch(input logic [2:0] cmd, input logic [127:0] w);
		bit          hi;
		longint      arr, dl, now, wt, k;
		logic [15:0] id, busy;
		int          s;
		decision_t   d;
		hi = w[0];
		arr = w[31:1];
		dl = w[62:32];
		id = w[78:63];
		now = w[109:79];
		busy = w[125:110];
		wt = hi ? w_high : w_low;
		k = (now > dl) ? longint'(mltd_pkg::EXPIRED_KEY) : wt * (dl - arr);
		case (cmd)
			mltd_pkg::CMD_TIMER: begin
				ticks = ticks + 1;
			end
			mltd_pkg::CMD_ARRIVAL: begin
				place(id, 0, k, 0);
			end
			mltd_pkg::CMD_FINISH: begin
				s = lookup(id, 0);
				if (s >= 0) occupied[s] = 0;
				s = lookup(id, 1);
				if (s >= 0) occupied[s] = 0;
			end
			mltd_pkg::CMD_IO_REQ: begin
				s = lookup(id, 0);
				if (s >= 0) begin
					on_io[s] = 1;
					sort_key[s] = k;
					if (bursts[s] < 255) bursts[s]++;
				end else begin
					place(id, 1, k, 1);
				end
			end
			mltd_pkg::CMD_IO_END: begin
				s = lookup(id, 1);
				if (s >= 0) begin
					on_io[s] = 0;
					sort_key[s] = k;
				end else begin
					place(id, 0, k, 0);
				end
			end
			mltd_pkg::CMD_DECIDE: begin
				if (period != 0 && ticks % period == 0) begin
					for (int i = 0; i < NSLOT; i++) bursts[i] = 0;
				end
				d.io = busy;
				if (busy == 16'd0) begin
					s = lowest_key(1, -1);
					d.io = (s >= 0) ? owner[s] : 16'd0;
				end
				d.cpu = 16'd0;
				if (lowest_key(0, -1) >= 0) begin
					s = -1;
					for (int t = 0; t < 65535 && s < 0; t++) begin
						s = lowest_key(0, int'(draw() % NLVL));
					end
					for (int l = 0; l < NLVL && s < 0; l++) begin
						s = lowest_key(0, l);
					end
					if (s >= 0) d.cpu = owner[s];
				end
				d.ovf = full_seen;
				decisions_due.insert(decisions_due.size(), d);
			end
			default: begin
			end
		endcase
	endtask

	assign pending = decisions_due.size();

	always @(posedge clk) begin
		decision_t d;
		if (!arst_n) begin
			errors = 0;
			clear_state();
			decisions_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (decisions_due.size() == 0) begin
					errors++;
					$display("%0t unexpected word: actual %h", $time, m_tdata);
				end else begin
					d = decisions_due.pop_front();
					if (m_tdata[15:0] !== d.cpu) begin
						errors++;
						$display("%0t cpu_task: expected %0d actual %0d", $time, d.cpu,
							m_tdata[15:0]);
					end
					if (m_tdata[31:16] !== d.io) begin
						errors++;
						$display("%0t io_task: expected %0d actual %0d", $time, d.io,
							m_tdata[31:16]);
					end
					if (m_tdata[32] !== d.ovf) begin
						errors++;
						$display("%0t table_overflow: expected %0d actual %0d", $time,
							d.ovf, m_tdata[32]);
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					mltd_pkg::REG_LEVEL_ZERO: lim0 = pwdata[7:0];
					mltd_pkg::REG_LEVEL_ONE:  lim1 = pwdata[7:0];
					mltd_pkg::REG_PERIOD:     period = pwdata[15:0];
					mltd_pkg::REG_HIGH_WGT:   w_high = pwdata[3:0];
					mltd_pkg::REG_LOW_WGT:    w_low = pwdata[3:0];
					mltd_pkg::REG_SEED: begin
						seed = pwdata[15:0];
						lfsr = seed_fix(seed);
					end
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				dispatch(s_tuser, s_tdata);
			end
		end
	end

endmodule

// ===== dv/tb_multilevel_deadline_task_dispatcher.sv =====
`timescale 1ns / 1ps
module tb_multilevel_deadline_task_dispatcher;

	localparam int STALL_LIMIT = 20000;
	localparam int PER_PHASE   = 290;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// high_priority, arrival_time, deadline, task_id, event_time, busy_io_task
	logic [127:0] s_tdata;
	// cmd
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	// cpu_task, io_task, table_overflow
	logic [39:0]  m_tdata;
	logic         psel, penable, pwrite, pready;
	logic [4:0]   paddr;
	logic [31:0]  pwdata, prdata;
	int           errors, pending;
	bit           calm;
	bit           hold_req;
	bit           stim_done;
	int           quiet_cycles = 0;

	multilevel_deadline_task_dispatcher dut (.*);

	mltd_checker chk (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .psel(psel), .penable(penable), .pwrite(pwrite),
		.pready(pready), .paddr(paddr), .pwdata(pwdata), .errors(errors),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic send_word(input logic [2:0] cmd, input bit hi, input logic [30:0] arr,
			input logic [30:0] dl, input logic [15:0] id, input logic [30:0] now,
			input logic [15:0] busy);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {2'b00, busy, now, id, dl, arr, hi};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	function automatic logic [30:0] pick_time();
		case ($urandom_range(0, 5))
			0: return 31'd0;
			1: return 31'h7FFF_FFFF;
			2, 3: return 31'($urandom_range(0, 60));
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_id();
		if ($urandom_range(0, 19) == 0) begin
			return 16'($urandom);
		end
		return 16'($urandom_range(1, 24));
	endfunction

	task automatic random_word(input int finish_bias);
		int          r;
		logic [2:0]  cmd;
		logic [15:0] busy;
		r = $urandom_range(0, 99);
		if (r < 28) cmd = mltd_pkg::CMD_ARRIVAL;
		else if (r < 28 + finish_bias) cmd = mltd_pkg::CMD_FINISH;
		else if (r < 55) cmd = mltd_pkg::CMD_IO_REQ;
		else if (r < 67) cmd = mltd_pkg::CMD_IO_END;
		else if (r < 80) cmd = mltd_pkg::CMD_TIMER;
		else if (r < 98) cmd = mltd_pkg::CMD_DECIDE;
		else cmd = 3'($urandom_range(6, 7));
		busy = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
		sender_gap();
		send_word(cmd, 1'($urandom_range(0, 1)), pick_time(), pick_time(), pick_id(),
			pick_time(), busy);
	endtask

	always begin
		m_tready <= 1'b0;
		@(negedge clk);
		while (arst_n !== 1'b1) @(negedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		calm = 0;
		hold_req = 0;
		stim_done = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = mltd_pkg::CMD_TIMER;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_word(mltd_pkg::CMD_DECIDE, 0, 0, 0, 0, 0, 0);
		send_word(mltd_pkg::CMD_ARRIVAL, 1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF,
			31'h7FFF_FFFF, 0);
		send_word(mltd_pkg::CMD_ARRIVAL, 0, 0, 31'h7FFF_FFFF, 16'h0001, 0, 0);
		send_word(mltd_pkg::CMD_ARRIVAL, 1, 31'h7FFF_FFFF, 0, 16'h0002, 0, 0);
		send_word(mltd_pkg::CMD_ARRIVAL, 0, 5, 10, 16'h0003, 11, 0);
		send_word(mltd_pkg::CMD_ARRIVAL, 0, 5, 10, 16'h0004, 10, 0);
		send_word(mltd_pkg::CMD_DECIDE, 0, 0, 0, 0, 0, 16'hFFFF);
		send_word(mltd_pkg::CMD_IO_REQ, 1, 1, 40, 16'h0001, 2, 0);
		send_word(mltd_pkg::CMD_IO_REQ, 0, 3, 4, 16'h0077, 9, 0);
		send_word(mltd_pkg::CMD_DECIDE, 0, 0, 0, 0, 0, 0);
		send_word(mltd_pkg::CMD_IO_END, 0, 2, 8, 16'h0001, 3, 0);
		send_word(mltd_pkg::CMD_IO_END, 1, 2, 8, 16'h0055, 3, 0);
		send_word(mltd_pkg::CMD_TIMER, 0, 0, 0, 0, 0, 0);
		send_word(3'd6, 1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF,
			16'hFFFF);
		send_word(3'd7, 0, 0, 0, 0, 0, 0);
		send_word(mltd_pkg::CMD_DECIDE, 1, 0, 0, 0, 0, 16'h0001);
		send_word(mltd_pkg::CMD_FINISH, 0, 0, 0, 16'hFFFF, 0, 0);
		send_word(mltd_pkg::CMD_FINISH, 0, 0, 0, 16'h0077, 0, 0);
		send_word(mltd_pkg::CMD_FINISH, 0, 0, 0, 16'h4242, 0, 0);
		send_word(mltd_pkg::CMD_DECIDE, 0, 0, 0, 0, 0, 0);

		for (int phase = 0; phase < 6; phase++) begin
			drain();
			case (phase)
				1: begin
					reg_write(mltd_pkg::REG_LEVEL_ZERO, 0);
					reg_write(mltd_pkg::REG_LEVEL_ONE, 0);
					reg_write(mltd_pkg::REG_PERIOD, 1);
					reg_write(mltd_pkg::REG_HIGH_WGT, 15);
					reg_write(mltd_pkg::REG_LOW_WGT, 0);
					reg_write(mltd_pkg::REG_SEED, 32'h0000_FFFF);
				end
				2: begin
					reg_write(mltd_pkg::REG_LEVEL_ZERO, 255);
					reg_write(mltd_pkg::REG_LEVEL_ONE, 255);
					reg_write(mltd_pkg::REG_PERIOD, 65535);
					reg_write(mltd_pkg::REG_HIGH_WGT, 0);
					reg_write(mltd_pkg::REG_LOW_WGT, 15);
					reg_write(mltd_pkg::REG_SEED, 1);
				end
				3: begin
					reg_write(mltd_pkg::REG_LEVEL_ZERO, 1);
					reg_write(mltd_pkg::REG_LEVEL_ONE, 2);
					reg_write(mltd_pkg::REG_PERIOD, 3);
					reg_write(mltd_pkg::REG_HIGH_WGT, 7);
					reg_write(mltd_pkg::REG_LOW_WGT, 3);
					reg_write(mltd_pkg::REG_SEED, 32'h0000_ACE1);
				end
				4: begin
					reg_write(mltd_pkg::REG_LEVEL_ZERO, $urandom_range(0, 255));
					reg_write(mltd_pkg::REG_LEVEL_ONE, $urandom_range(0, 255));
					reg_write(mltd_pkg::REG_PERIOD, $urandom_range(1, 65535));
					reg_write(mltd_pkg::REG_HIGH_WGT, $urandom_range(0, 15));
					reg_write(mltd_pkg::REG_LOW_WGT, $urandom_range(0, 15));
					reg_write(mltd_pkg::REG_SEED, $urandom_range(1, 65535));
				end
				5: begin
					reg_write(mltd_pkg::REG_LEVEL_ZERO, 5);
					reg_write(mltd_pkg::REG_LEVEL_ONE, 2);
					reg_write(mltd_pkg::REG_PERIOD, 2);
					reg_write(mltd_pkg::REG_HIGH_WGT, 15);
					reg_write(mltd_pkg::REG_LOW_WGT, 15);
					reg_write(mltd_pkg::REG_SEED, $urandom_range(1, 65535));
				end
				default: begin
				end
			endcase
			if (phase == 1) hold_req = 1;
			for (int n = 0; n < PER_PHASE; n++) begin
				if (phase == 5 && n == PER_PHASE - 100) calm = 1;
				random_word((phase % 2 == 0) ? 10 : 18);
			end
		end
		s_tvalid <= 1'b0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
